// File: src/bet_pkg.sv
// Package for the breakpoint envelope table.
// Holds the default sizes, command, status and controller state codes.
// Used by bet_div and the top level; depends on nothing.
`timescale 1ns / 1ps
package bet_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int TIME_BITS_DEF    = 16;
  localparam int VALUE_BITS_DEF   = 16;
  localparam int MIN_STEP_RESET   = 10;
  localparam int CMD_BITS         = 4;
  localparam int STATUS_BITS      = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT       = 4'd0,
    CMD_REMOVE_AT    = 4'd1,
    CMD_REMOVE_RANGE = 4'd2,
    CMD_CLEAR        = 4'd3,
    CMD_EVALUATE     = 4'd4,
    CMD_CLOSEST      = 4'd5,
    CMD_AFTER        = 4'd6,
    CMD_BEFORE       = 4'd7,
    CMD_EXTREMES     = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_DONE = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_INS,
    S_SCAN,
    S_DIVW
  } state_t;

endpackage

// File: src/bet_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by the breakpoint envelope table for its point store.
`timescale 1ns / 1ps
module bet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bet_div.sv
// Interpolation arithmetic: a registered multiply, then a restoring divider that
// retires one quotient bit per cycle. Depends on bet_pkg.
`timescale 1ns / 1ps
module bet_div
  import bet_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] mag,
  input  logic [TIME_BITS-1:0]  part,
  input  logic [TIME_BITS-1:0]  span,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot
);

  localparam int PW = VALUE_BITS + TIME_BITS;
  localparam int KW = $clog2(PW + 1);

  logic                  mul_r, mul_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [TIME_BITS-1:0]  part_r, part_nxt;
  logic [TIME_BITS-1:0]  span_r, span_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [TIME_BITS-1:0]  rem_r, rem_nxt;
  logic [TIME_BITS:0]    trial;
  logic                  fits;

  assign trial = {rem_r, prod_r[PW-1]};
  assign fits  = trial >= {1'b0, span_r};

  always_comb begin
    mul_nxt  = 1'b0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    mag_nxt  = mag_r;
    part_nxt = part_r;
    span_nxt = span_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (start) begin
      mul_nxt  = 1'b1;
      mag_nxt  = mag;
      part_nxt = part;
      span_nxt = span;
    end else if (mul_r) begin
      prod_nxt = PW'(mag_r) * PW'(part_r);
      rem_nxt  = '0;
      k_nxt    = KW'(PW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the span, so it fits the time width.
      rem_nxt  = fits ? TIME_BITS'(trial - {1'b0, span_r}) : trial[TIME_BITS-1:0];
      prod_nxt = {prod_r[PW-2:0], fits};
      k_nxt    = k_r - 1'b1;
      if (k_r == KW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      mul_r  <= mul_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    mag_r  <= mag_nxt;
    part_r <= part_nxt;
    span_r <= span_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = prod_r[VALUE_BITS-1:0];

endmodule

// File: src/breakpoint_envelope_table.sv
// Breakpoint envelope table top level: command controller around the point
// store. Depends on bet_pkg, bet_ram and bet_div.
`timescale 1ns / 1ps
// The table keeps up to MAX_POINTS (time, value) points, sorted by time, in
// one RAM of {time, value} words. A command is taken when start is high and
// busy is low; its single result appears for one cycle with out_strobe and
// cannot be held off. Remove and query commands walk the RAM once at one entry
// per cycle through its single read port; insert takes a removal walk plus a
// shifting walk from the top, and evaluate then runs the multiply and the
// divider before it takes the quotient. Clear and unknown commands answer
// without a walk.
// The minimum step register may be written whenever busy is low.
module breakpoint_envelope_table
  import bet_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [CMD_BITS-1:0]               in_command,
  input  logic [TIME_BITS-1:0]              in_point_time,
  input  logic signed [VALUE_BITS-1:0]      in_point_value,
  input  logic [TIME_BITS-1:0]              in_range_end,
  output logic                              out_strobe,
  output logic [STATUS_BITS-1:0]            out_status,
  output logic [TIME_BITS-1:0]              out_time,
  output logic signed [VALUE_BITS-1:0]      out_value,
  output logic [TIME_BITS-1:0]              out_time_high,
  output logic signed [VALUE_BITS-1:0]      out_value_high,
  output logic [$clog2(MAX_POINTS+1)-1:0]   out_point_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [TIME_BITS-1:0]              cfg_min_time_step
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = TIME_BITS + VALUE_BITS;

  state_t state_r, state_nxt;

  logic [CMD_BITS-1:0]          cmd_r, cmd_nxt;
  logic [TIME_BITS-1:0]         t_r, t_nxt;
  logic signed [VALUE_BITS-1:0] v_r, v_nxt;
  logic [TIME_BITS-1:0]         e_r, e_nxt;
  logic [TIME_BITS-1:0]         step_r;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                rd_r, rd_nxt;
  logic [CW-1:0]                w_r, w_nxt;
  logic                         pend_r, pend_nxt;
  logic [AW-1:0]                pi_r, pi_nxt;

  logic                         has_lo_r, has_lo_nxt, has_hi_r, has_hi_nxt;
  logic [TIME_BITS-1:0]         lo_t_r, lo_t_nxt, hi_t_r, hi_t_nxt;
  logic signed [VALUE_BITS-1:0] lo_v_r, lo_v_nxt, hi_v_r, hi_v_nxt;
  logic [TIME_BITS-1:0]         best_r, best_nxt, cl_t_r, cl_t_nxt;
  logic signed [VALUE_BITS-1:0] cl_v_r, cl_v_nxt;
  logic [TIME_BITS-1:0]         first_t_r, first_t_nxt, last_t_r, last_t_nxt;
  logic signed [VALUE_BITS-1:0] min_v_r, min_v_nxt, max_v_r, max_v_nxt;

  logic                         strobe_r, strobe_nxt;
  logic [STATUS_BITS-1:0]       status_r, status_nxt;
  logic [TIME_BITS-1:0]         ot_r, ot_nxt, oth_r, oth_nxt;
  logic signed [VALUE_BITS-1:0] ov_r, ov_nxt, ovh_r, ovh_nxt;
  logic [CW-1:0]                ocnt_r, ocnt_nxt;

  logic                         we;
  logic [AW-1:0]                waddr, raddr;
  logic [EW-1:0]                wdata, rdata;
  logic [TIME_BITS-1:0]         d_t, gap_t;
  logic signed [VALUE_BITS-1:0] d_v;
  logic [CW-1:0]                rd_m1;
  logic                         scan_end, ins_done, full, hit, want_div;
  logic signed [VALUE_BITS:0]   dv, ov_div;
  logic [VALUE_BITS-1:0]        mag;
  logic                         div_start, div_done;
  logic [VALUE_BITS-1:0]        quot;

  assign d_t      = rdata[EW-1:VALUE_BITS];
  assign d_v      = rdata[VALUE_BITS-1:0];
  assign gap_t    = (d_t > t_r) ? d_t - t_r : t_r - d_t;
  assign rd_m1    = rd_r - 1'b1;
  assign scan_end = (rd_r == cnt_r) && !pend_r;
  assign ins_done = pend_r ? !(d_t > t_r) : (rd_r == '0);
  assign full     = w_r >= CW'(MAX_POINTS);
  assign want_div = (cmd_r == CMD_EVALUATE) && has_lo_r && has_hi_r;

  always_comb begin
    case (cmd_r)
      CMD_INSERT:       hit = gap_t < step_r;
      CMD_REMOVE_AT:    hit = d_t == t_r;
      CMD_REMOVE_RANGE: hit = (d_t > t_r) && (d_t < e_r);
      default:          hit = 1'b0;
    endcase
  end

  // Interpolation operands; the magnitude of the value step fits VALUE_BITS.
  assign dv        = (VALUE_BITS+1)'(hi_v_r) - (VALUE_BITS+1)'(lo_v_r);
  assign mag       = dv[VALUE_BITS] ? VALUE_BITS'(-dv) : VALUE_BITS'(dv);
  assign div_start = (state_r == S_SCAN) && scan_end && want_div;
  assign ov_div    = dv[VALUE_BITS]
                   ? (VALUE_BITS+1)'(lo_v_r) - $signed({1'b0, quot})
                   : (VALUE_BITS+1)'(lo_v_r) + $signed({1'b0, quot});

  bet_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bet_div #(
    .TIME_BITS (TIME_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .mag  (mag),
    .part (t_r - lo_t_r),
    .span (hi_t_r - lo_t_r),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_INSERT, CMD_REMOVE_AT, CMD_REMOVE_RANGE: state_nxt = S_DROP;
            CMD_EVALUATE, CMD_CLOSEST, CMD_AFTER, CMD_BEFORE,
            CMD_EXTREMES: state_nxt = S_SCAN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DROP: begin
        if (scan_end) begin
          state_nxt = (cmd_r == CMD_INSERT && !full) ? S_INS : S_IDLE;
        end
      end
      S_INS: begin
        if (ins_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = want_div ? S_DIVW : S_IDLE;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    t_nxt       = t_r;
    v_nxt       = v_r;
    e_nxt       = e_r;
    cnt_nxt     = cnt_r;
    rd_nxt      = rd_r;
    w_nxt       = w_r;
    pend_nxt    = 1'b0;
    pi_nxt      = pi_r;
    has_lo_nxt  = has_lo_r;
    has_hi_nxt  = has_hi_r;
    lo_t_nxt    = lo_t_r;
    lo_v_nxt    = lo_v_r;
    hi_t_nxt    = hi_t_r;
    hi_v_nxt    = hi_v_r;
    best_nxt    = best_r;
    cl_t_nxt    = cl_t_r;
    cl_v_nxt    = cl_v_r;
    first_t_nxt = first_t_r;
    last_t_nxt  = last_t_r;
    min_v_nxt   = min_v_r;
    max_v_nxt   = max_v_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    ot_nxt      = ot_r;
    ov_nxt      = ov_r;
    oth_nxt     = oth_r;
    ovh_nxt     = ovh_r;
    ocnt_nxt    = ocnt_r;
    we          = 1'b0;
    waddr       = w_r[AW-1:0];
    wdata       = rdata;
    raddr       = rd_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          t_nxt      = in_point_time;
          v_nxt      = in_point_value;
          e_nxt      = in_range_end;
          rd_nxt     = '0;
          w_nxt      = '0;
          has_lo_nxt = 1'b0;
          has_hi_nxt = 1'b0;
          case (in_command)
            CMD_INSERT, CMD_REMOVE_AT, CMD_REMOVE_RANGE, CMD_EVALUATE,
            CMD_CLOSEST, CMD_AFTER, CMD_BEFORE, CMD_EXTREMES: begin
            end
            CMD_CLEAR: begin
              cnt_nxt    = '0;
              strobe_nxt = 1'b1;
              status_nxt = STAT_DONE;
              ot_nxt     = '0;
              ov_nxt     = '0;
              oth_nxt    = '0;
              ovh_nxt    = '0;
              ocnt_nxt   = '0;
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = STAT_NONE;
              ot_nxt     = '0;
              ov_nxt     = '0;
              oth_nxt    = '0;
              ovh_nxt    = '0;
              ocnt_nxt   = cnt_r;
            end
          endcase
        end
      end

      // Compaction walk: read ahead one entry, write kept entries down to w.
      S_DROP: begin
        if (rd_r != cnt_r) begin
          pend_nxt = 1'b1;
          pi_nxt   = rd_r[AW-1:0];
          rd_nxt   = rd_r + 1'b1;
        end
        if (pend_r && !hit) begin
          we    = 1'b1;
          w_nxt = w_r + 1'b1;
        end
        if (scan_end) begin
          cnt_nxt = w_r;
          rd_nxt  = w_r;
          if (cmd_r != CMD_INSERT || full) begin
            strobe_nxt = 1'b1;
            ot_nxt     = '0;
            ov_nxt     = '0;
            oth_nxt    = '0;
            ovh_nxt    = '0;
            ocnt_nxt   = w_r;
            if (cmd_r == CMD_INSERT) begin
              status_nxt = STAT_FULL;
            end else begin
              status_nxt = (w_r != cnt_r) ? STAT_DONE : STAT_NONE;
            end
          end
        end
      end

      // Shift walk from the top: move later points up one slot until the
      // new point's place is found.
      S_INS: begin
        raddr = rd_m1[AW-1:0];
        if (rd_r != '0 && !(pend_r && !(d_t > t_r))) begin
          pend_nxt = 1'b1;
          pi_nxt   = rd_m1[AW-1:0];
          rd_nxt   = rd_m1;
        end
        if (pend_r) begin
          we    = 1'b1;
          waddr = pi_r + 1'b1;
          if (!(d_t > t_r)) begin
            wdata = {t_r, v_r};
          end
        end else if (rd_r == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = {t_r, v_r};
        end
        if (ins_done) begin
          cnt_nxt    = cnt_r + 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = STAT_DONE;
          ot_nxt     = '0;
          ov_nxt     = '0;
          oth_nxt    = '0;
          ovh_nxt    = '0;
          ocnt_nxt   = cnt_r + 1'b1;
        end
      end

      S_SCAN: begin
        if (rd_r != cnt_r) begin
          pend_nxt = 1'b1;
          pi_nxt   = rd_r[AW-1:0];
          rd_nxt   = rd_r + 1'b1;
        end
        if (pend_r) begin
          if (d_t < t_r) begin
            has_lo_nxt = 1'b1;
            lo_t_nxt   = d_t;
            lo_v_nxt   = d_v;
          end
          if (!has_hi_r && d_t > t_r) begin
            has_hi_nxt = 1'b1;
            hi_t_nxt   = d_t;
            hi_v_nxt   = d_v;
          end
          if (pi_r == '0 || gap_t < best_r) begin
            best_nxt = gap_t;
            cl_t_nxt = d_t;
            cl_v_nxt = d_v;
          end
          if (pi_r == '0) begin
            first_t_nxt = d_t;
            min_v_nxt   = d_v;
            max_v_nxt   = d_v;
          end else begin
            if (d_v < min_v_r) min_v_nxt = d_v;
            if (d_v > max_v_r) max_v_nxt = d_v;
          end
          last_t_nxt = d_t;
        end
        if (scan_end && !want_div) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_NONE;
          ot_nxt     = '0;
          ov_nxt     = '0;
          oth_nxt    = '0;
          ovh_nxt    = '0;
          ocnt_nxt   = cnt_r;
          case (cmd_r)
            CMD_CLOSEST: begin
              if (cnt_r != '0) begin
                status_nxt = STAT_DONE;
                ot_nxt     = cl_t_r;
                ov_nxt     = cl_v_r;
              end
            end
            CMD_AFTER: begin
              if (has_hi_r) begin
                status_nxt = STAT_DONE;
                ot_nxt     = hi_t_r;
                ov_nxt     = hi_v_r;
              end
            end
            CMD_BEFORE: begin
              if (has_lo_r) begin
                status_nxt = STAT_DONE;
                ot_nxt     = lo_t_r;
                ov_nxt     = lo_v_r;
              end
            end
            CMD_EXTREMES: begin
              if (cnt_r != '0) begin
                status_nxt = STAT_DONE;
                ot_nxt     = first_t_r;
                ov_nxt     = min_v_r;
                oth_nxt    = last_t_r;
                ovh_nxt    = max_v_r;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DIVW: begin
        if (div_done) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_DONE;
          ot_nxt     = '0;
          ov_nxt     = VALUE_BITS'(ov_div);
          oth_nxt    = '0;
          ovh_nxt    = '0;
          ocnt_nxt   = cnt_r;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      step_r   <= TIME_BITS'(MIN_STEP_RESET);
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_min_time_step;
      end
    end
    cmd_r     <= cmd_nxt;
    t_r       <= t_nxt;
    v_r       <= v_nxt;
    e_r       <= e_nxt;
    rd_r      <= rd_nxt;
    w_r       <= w_nxt;
    pi_r      <= pi_nxt;
    has_lo_r  <= has_lo_nxt;
    has_hi_r  <= has_hi_nxt;
    lo_t_r    <= lo_t_nxt;
    lo_v_r    <= lo_v_nxt;
    hi_t_r    <= hi_t_nxt;
    hi_v_r    <= hi_v_nxt;
    best_r    <= best_nxt;
    cl_t_r    <= cl_t_nxt;
    cl_v_r    <= cl_v_nxt;
    first_t_r <= first_t_nxt;
    last_t_r  <= last_t_nxt;
    min_v_r   <= min_v_nxt;
    max_v_r   <= max_v_nxt;
    status_r  <= status_nxt;
    ot_r      <= ot_nxt;
    ov_r      <= ov_nxt;
    oth_r     <= oth_nxt;
    ovh_r     <= ovh_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign cfg_ready       = 1'b1;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_time        = ot_r;
  assign out_value       = ov_r;
  assign out_time_high   = oth_r;
  assign out_value_high  = ovh_r;
  assign out_point_count = ocnt_r;

  // A result beat always lands with the controller back at idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while busy");

  // Every accepted command either keeps the block busy or answers at once.
  a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted command produced neither work nor result");

  // The divider only finishes while the controller waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider result outside evaluate");

  // The stored count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count beyond table depth");

endmodule
